[sv/i2c_master_register_transfer_defines.svh]
// Assertion macros used by the checker file of the register transfer sequencer
`ifndef I2C_MASTER_REGISTER_TRANSFER_DEFINES_SVH
`define I2C_MASTER_REGISTER_TRANSFER_DEFINES_SVH

// clocked check, switched off while reset is asserted
`define I2CMRT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define I2CMRT_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/i2cmrt_pkg.sv]
// Types and constants of the register transfer sequencer
package i2cmrt_pkg;

	localparam logic [1:0] FUNC_START  = 2'd0;
	localparam logic [1:0] FUNC_STATUS = 2'd1;
	localparam logic [1:0] FUNC_LOAD   = 2'd2;

	localparam logic [2:0] CMD_NONE  = 3'd0;
	localparam logic [2:0] CMD_NACK  = 3'd1;
	localparam logic [2:0] CMD_ACK   = 3'd2;
	localparam logic [2:0] CMD_START = 3'd3;
	localparam logic [2:0] CMD_STOP  = 3'd4;

	localparam logic [7:0] STATUS_MASK   = 8'hF8;
	localparam logic [7:0] ST_START      = 8'h08;
	localparam logic [7:0] ST_RESTART    = 8'h10;
	localparam logic [7:0] ST_SLAW_ACK   = 8'h18;
	localparam logic [7:0] ST_SLAW_NACK  = 8'h20;
	localparam logic [7:0] ST_TXD_ACK    = 8'h28;
	localparam logic [7:0] ST_TXD_NACK   = 8'h30;
	localparam logic [7:0] ST_ARB_LOST   = 8'h38;
	localparam logic [7:0] ST_SLAR_ACK   = 8'h40;
	localparam logic [7:0] ST_SLAR_NACK  = 8'h48;
	localparam logic [7:0] ST_RXD_ACK    = 8'h50;
	localparam logic [7:0] ST_RXD_NACK   = 8'h58;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ADDRESS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REGISTER_INDEX  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TRANSFER_LENGTH = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_READ_MODE       = 2'd3;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] bus_status;
		logic [7:0] bus_data;
		logic [4:0] load_index;
		logic [7:0] load_byte;
	} item_t;

	typedef struct packed {
		logic [2:0] bus_command;
		logic       drive_valid;
		logic [7:0] drive_byte;
		logic       rx_valid;
		logic [7:0] rx_byte;
		logic [5:0] rx_position;
		logic       done_res;
		logic [7:0] status_code;
		logic [6:0] bytes_done;
	} result_t;

	typedef struct packed {
		logic [6:0] slave_address;
		logic [7:0] register_index;
		logic [5:0] transfer_length;
		logic       read_mode;
	} cfg_t;

	typedef struct packed {
		logic [5:0] rx_counter;
		logic [5:0] tx_counter;
		logic [7:0] last_status;
	} state_t;

endpackage

[sv/i2cmrt_ifs.sv]
// Item and result channel interfaces of the register transfer sequencer
interface i2cmrt_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [7:0] bus_status;
	logic [7:0] bus_data;
	logic [4:0] load_index;
	logic [7:0] load_byte;

	modport source (output valid, func, bus_status, bus_data, load_index, load_byte,
		input ready);
	modport sink (input valid, func, bus_status, bus_data, load_index, load_byte,
		output ready);
endinterface

interface i2cmrt_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] bus_command;
	logic       drive_valid;
	logic [7:0] drive_byte;
	logic       rx_valid;
	logic [7:0] rx_byte;
	logic [5:0] rx_position;
	logic       done_res;
	logic [7:0] status_code;
	logic [6:0] bytes_done;

	modport source (output valid, bus_command, drive_valid, drive_byte, rx_valid, rx_byte,
		rx_position, done_res, status_code, bytes_done, input ready);
	modport sink (input valid, bus_command, drive_valid, drive_byte, rx_valid, rx_byte,
		rx_position, done_res, status_code, bytes_done, output ready);
endinterface

[sv/i2c_master_register_transfer.sv]
// Top level of the I2C master register transfer sequencer
// Usage notes
// - item channel: one word per event. func selects start (clears the byte
//   counters, asks for START), status (bus status byte, masked to its upper
//   five bits and decoded) or load (stores a byte in the transmit buffer).
// - result channel: exactly one word per item, carrying the bus command,
//   an optional byte to drive, an optional received byte with its position,
//   the done flag, the last status code and the byte count.
// - config port: cfg_we/cfg_index/cfg_data write slave address, register
//   index, transfer length and read mode; write only while no word is in
//   flight.
// - the accepted word passes the input register, then is decoded into the
//   result register, which drives the result channel.
// - throughput: one word per cycle unless the receiver stalls; the decode
//   and counter update sit in a single stage between the input and result
//   registers.
// - the transmit buffer has one write and one read port; the registered read
//   always holds the entry at the current transmit count; a load to that
//   entry is forwarded.
// - reset clears counters, last status, configuration and both valid flags;
//   buffer contents stay undefined until loaded.
// - receiver stall: the result register holds, the input register still
//   takes one more word, then item.ready drops until result.ready returns.
module i2c_master_register_transfer
	import i2cmrt_pkg::*;
#(
	parameter int MAX_LEN = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	i2cmrt_item_if.sink           item,
	i2cmrt_result_if.source       result
);

	// buffer address width; at least one bit
	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

	cfg_t       cfg_q;
	logic       v_s1;
	item_t      item_s1;
	state_t     state_q;
	state_t     st_nxt;
	result_t    res_nxt;
	result_t    res_q;
	logic       res_valid_q;
	logic       adv;
	logic       fire_s1;
	logic       mem_we;
	logic [5:0] load_idx6;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	logic [5:0] tx_next;
	logic [7:0] rd_q;
	logic [7:0] tx_byte;
	logic [7:0] tx_mem [MAX_LEN];

	// handshake: result register frees when empty or being taken
	assign adv        = !res_valid_q || result.ready;
	assign item.ready = !v_s1 || adv;
	assign fire_s1    = v_s1 && adv;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SLAVE_ADDRESS:   cfg_q.slave_address   <= cfg_data[6:0];
				CFG_REGISTER_INDEX:  cfg_q.register_index  <= cfg_data;
				CFG_TRANSFER_LENGTH: cfg_q.transfer_length <= cfg_data[5:0];
				CFG_READ_MODE:       cfg_q.read_mode       <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (item.ready) begin
			v_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.func       <= item.func;
			item_s1.bus_status <= item.bus_status;
			item_s1.bus_data   <= item.bus_data;
			item_s1.load_index <= item.load_index;
			item_s1.load_byte  <= item.load_byte;
		end
	end

	// transmit buffer: loads beyond the buffer are dropped
	assign load_idx6 = {1'b0, item_s1.load_index};
	assign wr_addr   = load_idx6[AW-1:0];
	assign mem_we    = fire_s1 && (item_s1.func == FUNC_LOAD) &&
		({1'b0, load_idx6} < 7'(MAX_LEN));

	// read address follows the transmit count as it will be after this edge
	assign tx_next = fire_s1 ? st_nxt.tx_counter : state_q.tx_counter;
	assign rd_addr = tx_next[AW-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			tx_mem[wr_addr] <= item_s1.load_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we && (wr_addr == rd_addr)) begin
			rd_q <= item_s1.load_byte;
		end else begin
			rd_q <= tx_mem[rd_addr];
		end
	end

	// positions at or beyond the buffer send zero
	assign tx_byte = ({1'b0, state_q.tx_counter} < 7'(MAX_LEN)) ? rd_q : 8'h00;

	i2cmrt_step u_step (
		.item_w  (item_s1),
		.cfg     (cfg_q),
		.st      (state_q),
		.tx_byte (tx_byte),
		.st_nxt  (st_nxt),
		.res     (res_nxt)
	);

	// counters and last status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (fire_s1) begin
			state_q <= st_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			res_q <= res_nxt;
		end
	end

	assign result.valid       = res_valid_q;
	assign result.bus_command = res_q.bus_command;
	assign result.drive_valid = res_q.drive_valid;
	assign result.drive_byte  = res_q.drive_byte;
	assign result.rx_valid    = res_q.rx_valid;
	assign result.rx_byte     = res_q.rx_byte;
	assign result.rx_position = res_q.rx_position;
	assign result.done_res    = res_q.done_res;
	assign result.status_code = res_q.status_code;
	assign result.bytes_done  = res_q.bytes_done;

endmodule

[sv/i2cmrt_step.sv]
// Status decode and counter update for one word
module i2cmrt_step
	import i2cmrt_pkg::*;
(
	input  item_t      item_w,
	input  cfg_t       cfg,
	input  state_t     st,
	input  logic [7:0] tx_byte,
	output state_t     st_nxt,
	output result_t    res
);

	logic [7:0] code;
	logic [7:0] addr_w;
	logic [5:0] rx_inc;

	assign code   = item_w.bus_status & STATUS_MASK;
	assign addr_w = {cfg.slave_address, 1'b0};
	assign rx_inc = st.rx_counter + 6'd1;

	always_comb begin
		st_nxt = st;
		res    = '0;
		unique case (item_w.func)
			FUNC_START: begin
				st_nxt.rx_counter = '0;
				st_nxt.tx_counter = '0;
				res.bus_command   = CMD_START;
			end
			FUNC_STATUS: begin
				st_nxt.last_status = code;
				unique case (code)
					ST_START: begin
						res.drive_valid = 1'b1;
						res.drive_byte  = addr_w;
						res.bus_command = CMD_NACK;
					end
					ST_RESTART: begin
						res.drive_valid = 1'b1;
						res.drive_byte  = {addr_w[7:1], cfg.read_mode};
						res.bus_command = CMD_NACK;
					end
					ST_SLAW_ACK: begin
						res.drive_valid = 1'b1;
						res.drive_byte  = cfg.register_index;
						res.bus_command = CMD_NACK;
					end
					ST_SLAW_NACK, ST_TXD_NACK: begin
						res.bus_command = CMD_STOP;
						res.done_res    = 1'b1;
					end
					ST_TXD_ACK: begin
						if (cfg.read_mode) begin
							res.bus_command = CMD_START;
						end else if (st.tx_counter < cfg.transfer_length) begin
							res.drive_valid   = 1'b1;
							res.drive_byte    = tx_byte;
							st_nxt.tx_counter = st.tx_counter + 6'd1;
							res.bus_command   = CMD_NACK;
						end else begin
							res.bus_command = CMD_STOP;
							res.done_res    = 1'b1;
						end
					end
					ST_ARB_LOST: begin
						res.bus_command = CMD_NACK;
						res.done_res    = 1'b1;
					end
					ST_SLAR_ACK: begin
						if (cfg.read_mode) begin
							res.bus_command = (cfg.transfer_length < 6'd2) ? CMD_NACK : CMD_ACK;
						end
					end
					ST_SLAR_NACK: begin
						if (cfg.read_mode) begin
							res.bus_command = CMD_STOP;
							res.done_res    = 1'b1;
						end
					end
					ST_RXD_ACK: begin
						if (cfg.read_mode) begin
							res.rx_valid      = 1'b1;
							res.rx_byte       = item_w.bus_data;
							res.rx_position   = st.rx_counter;
							st_nxt.rx_counter = rx_inc;
							res.bus_command   = (({1'b0, rx_inc} + 7'd1) <
								{1'b0, cfg.transfer_length}) ? CMD_ACK : CMD_NACK;
						end
					end
					ST_RXD_NACK: begin
						if (cfg.read_mode) begin
							res.rx_valid    = 1'b1;
							res.rx_byte     = item_w.bus_data;
							res.rx_position = st.rx_counter;
							res.bus_command = CMD_STOP;
							res.done_res    = 1'b1;
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
		res.status_code = st_nxt.last_status;
		res.bytes_done  = cfg.read_mode ? ({1'b0, st_nxt.rx_counter} + 7'd1)
			: {1'b0, st_nxt.tx_counter};
	end

endmodule

[sv/i2cmrt_checker.sv]
// Port-level checks of the register transfer sequencer and their binding
`include "i2c_master_register_transfer_defines.svh"

module i2cmrt_checker
	import i2cmrt_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       item_valid,
	input logic       item_ready,
	input logic       result_valid,
	input logic       result_ready,
	input logic [2:0] bus_command,
	input logic       done_res,
	input logic [7:0] status_code
);

	`I2CMRT_ASSERT_ALWAYS(a_no_result_in_reset, !arst_n |-> !result_valid, "result valid during reset")

	`I2CMRT_ASSERT(a_result_has_item, $rose(result_valid) |-> $past(item_valid && item_ready, 2), "result without accepted word")

	`I2CMRT_ASSERT(a_done_cmd, (result_valid && done_res) |-> (bus_command == CMD_STOP || bus_command == CMD_NACK), "done without stop or arbitration release")

	`I2CMRT_ASSERT(a_stall_hold, (result_valid && !result_ready) |=> (result_valid && $stable(status_code) && $stable(bus_command)), "stalled word changed")

endmodule

bind i2c_master_register_transfer i2cmrt_checker u_i2cmrt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.bus_command  (result.bus_command),
	.done_res     (result.done_res),
	.status_code  (result.status_code)
);
